// File: rtl/ffd_pkg.sv
// ============================================================================
// ffd_pkg
// Shared types and constants for the fixed frame deframer with acknowledge.
// ============================================================================
package ffd_pkg;

    localparam logic [7:0] HDR_FIRST  = 8'h11;
    localparam logic [7:0] HDR_SECOND = 8'h22;

    localparam logic KIND_COMMAND = 1'b0;
    localparam logic KIND_ACK     = 1'b1;

    localparam int unsigned STEP_W = 3;

    localparam logic [STEP_W-1:0] STEP_DECODED = 3'd0;
    localparam logic [STEP_W-1:0] STEP_HDR1    = 3'd1;
    localparam logic [STEP_W-1:0] STEP_HDR2    = 3'd2;
    localparam logic [STEP_W-1:0] STEP_CODE    = 3'd3;
    localparam logic [STEP_W-1:0] STEP_ZERO1   = 3'd4;
    localparam logic [STEP_W-1:0] STEP_ZERO2   = 3'd5;
    localparam logic [STEP_W-1:0] STEP_CHECK   = 3'd6;

    typedef struct packed {
        logic [7:0] command;
        logic [7:0] low;
        logic [7:0] high;
        logic [7:0] ack;
    } frame_rec_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  command;
        logic [15:0] value;
        logic [7:0]  tx_byte;
        logic        last;
    } result_t;

    function automatic result_t build_result(input logic [STEP_W-1:0] step,
                                             input frame_rec_t rec);
        result_t r;
        r.kind    = KIND_ACK;
        r.command = 8'd0;
        r.value   = 16'd0;
        r.tx_byte = 8'd0;
        r.last    = 1'b0;
        unique case (step) inside
            STEP_DECODED:
            begin
                r.kind    = KIND_COMMAND;
                r.command = rec.command;
                r.value   = {rec.high, rec.low};
            end
            STEP_HDR1:    r.tx_byte = HDR_FIRST;
            STEP_HDR2:    r.tx_byte = HDR_SECOND;
            STEP_CODE:    r.tx_byte = rec.ack;
            STEP_ZERO1,
            STEP_ZERO2:   r.tx_byte = 8'd0;
            STEP_CHECK:
            begin
                r.tx_byte = ~rec.ack;
                r.last    = 1'b1;
            end
            default:      r.tx_byte = 8'd0;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/fixed_frame_deframer_with_ack_top.sv
// ============================================================================
// fixed_frame_deframer_with_ack_top
// Serial frame deframer that checks the sum and queues the acknowledge reply.
// ============================================================================
//  channel | direction | handshake           | word
//  --------+-----------+---------------------+-------------------------------
//  cfg     | in        | cfg_valid/cfg_ready | cfg_data: ack code
//  in      | in        | in_valid/in_ready   | rx_byte
//  out     | out       | out_valid/out_ready | kind, command, value, tx_byte, last
//
//  One received word is taken every cycle while the frame queue has room.
//  A good frame yields seven output words, one per cycle from the back end while out_ready is high.
//  Reset returns the parser to hunting and clears the ack code and the queue.
//  A stalled output fills the queue; the input then stalls on a full queue.
// ============================================================================
module fixed_frame_deframer_with_ack_top #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        kind,
    output logic [7:0]  command,
    output logic [15:0] value,
    output logic [7:0]  tx_byte,
    output logic        last
);
    import ffd_pkg::*;

    logic       push_valid;
    logic       push_ready;
    frame_rec_t push_data;
    logic       pop_valid;
    logic       pop_ready;
    frame_rec_t pop_data;
    result_t    out_res;

    assign cfg_ready = 1'b1;
    assign in_ready  = push_ready;

    ffd_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_data   (cfg_data),
        .byte_fire  (in_valid && push_ready),
        .rx_byte    (rx_byte),
        .push_valid (push_valid),
        .push_data  (push_data)
    );

    ffd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    ffd_emitter u_emitter (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind    = out_res.kind;
    assign command = out_res.command;
    assign value   = out_res.value;
    assign tx_byte = out_res.tx_byte;
    assign last    = out_res.last;

endmodule

// File: rtl/ffd_parser.sv
// ============================================================================
// ffd_parser
// Front end: hunts for the header, collects the frame and checks its sum.
// ============================================================================
module ffd_parser (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    input  logic [7:0]          cfg_data,
    input  logic                byte_fire,
    input  logic [7:0]          rx_byte,
    output logic                push_valid,
    output ffd_pkg::frame_rec_t push_data
);
    import ffd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_SEEN,
        PH_CMD,
        PH_LOW,
        PH_HIGH,
        PH_CHK
    } phase_t;

    phase_t     phase_reg;
    phase_t     phase_next;
    logic [7:0] cmd_reg;
    logic [7:0] low_reg;
    logic [7:0] high_reg;
    logic [7:0] ack_code_reg;
    logic [7:0] sum;

    assign sum = cmd_reg + low_reg + high_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_HUNT: phase_next = (rx_byte == HDR_FIRST) ? PH_SEEN : PH_HUNT;
            PH_SEEN:
            begin
                if (rx_byte == HDR_SECOND)
                    phase_next = PH_CMD;
                else if (rx_byte == HDR_FIRST)
                    phase_next = PH_SEEN;
                else
                    phase_next = PH_HUNT;
            end
            PH_CMD:  phase_next = PH_LOW;
            PH_LOW:  phase_next = PH_HIGH;
            PH_HIGH: phase_next = PH_CHK;
            PH_CHK:  phase_next = PH_HUNT;
            default: phase_next = PH_HUNT;
        endcase
    end

    assign push_valid        = byte_fire && (phase_reg == PH_CHK) && (~sum == rx_byte);
    assign push_data.command = cmd_reg;
    assign push_data.low     = low_reg;
    assign push_data.high    = high_reg;
    assign push_data.ack     = ack_code_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            cmd_reg      <= 8'd0;
            low_reg      <= 8'd0;
            high_reg     <= 8'd0;
            ack_code_reg <= 8'd0;
        end
        else
        begin
            if (cfg_valid)
                ack_code_reg <= cfg_data;
            if (byte_fire)
            begin
                phase_reg <= phase_next;
                if (phase_reg == PH_CMD)
                    cmd_reg <= rx_byte;
                if (phase_reg == PH_LOW)
                    low_reg <= rx_byte;
                if (phase_reg == PH_HIGH)
                    high_reg <= rx_byte;
            end
        end
    end

endmodule

// File: rtl/ffd_queue.sv
// ============================================================================
// ffd_queue
// Small first-in first-out queue of good frames between front and back end.
// ============================================================================
module ffd_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    output logic                push_ready,
    input  ffd_pkg::frame_rec_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output ffd_pkg::frame_rec_t pop_data
);
    import ffd_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    frame_rec_t       mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_push && !do_pop)
                count_reg <= count_reg + 1'b1;
            else if (do_pop && !do_push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

// File: rtl/ffd_emitter.sv
// ============================================================================
// ffd_emitter
// Back end: turns each good frame into the decoded word and the reply bytes.
// ============================================================================
module ffd_emitter (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                pop_valid,
    output logic                pop_ready,
    input  ffd_pkg::frame_rec_t pop_data,
    output logic                out_valid,
    input  logic                out_ready,
    output ffd_pkg::result_t    out_res
);
    import ffd_pkg::*;

    logic              busy_reg;
    logic [STEP_W-1:0] step_reg;
    frame_rec_t        rec_reg;
    logic              out_valid_reg;
    result_t           out_res_reg;
    logic              load_en;

    assign load_en   = !out_valid_reg || out_ready;
    assign pop_ready = load_en && !busy_reg;
    assign out_valid = out_valid_reg;
    assign out_res   = out_res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= STEP_DECODED;
            out_valid_reg <= 1'b0;
        end
        else if (load_en)
        begin
            if (busy_reg)
            begin
                out_valid_reg <= 1'b1;
                if (step_reg == STEP_CHECK)
                begin
                    busy_reg <= 1'b0;
                    step_reg <= STEP_DECODED;
                end
                else
                begin
                    step_reg <= step_reg + 1'b1;
                end
            end
            else if (pop_valid)
            begin
                out_valid_reg <= 1'b1;
                busy_reg      <= 1'b1;
                step_reg      <= STEP_HDR1;
            end
            else
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_en)
        begin
            if (busy_reg)
                out_res_reg <= build_result(step_reg, rec_reg);
            else if (pop_valid)
            begin
                rec_reg     <= pop_data;
                out_res_reg <= build_result(STEP_DECODED, pop_data);
            end
        end
    end

endmodule

// File: tb/ffd_result_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// ffd_result_checker
// Watches the configuration, input and output channels of the deframer. It
// tracks the header hunt and the collected frame bytes, works out the decoded
// word and the six acknowledge words of every good frame, and compares each
// output word field by field with the oldest word still expected.
// ============================================================================
module ffd_result_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [7:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic        kind,
    input  logic [7:0]  command,
    input  logic [15:0] value,
    input  logic [7:0]  tx_byte,
    input  logic        last,
    output int          fail_count,
    output int          pending
);
    import ffd_pkg::*;

    typedef enum logic [2:0] {
        PH_HUNT = 3'd0,
        PH_SYNC = 3'd1,
        PH_CMD  = 3'd2,
        PH_LOW  = 3'd3,
        PH_HIGH = 3'd4,
        PH_SUM  = 3'd5
    } parse_phase_t;

    parse_phase_t parse_phase;
    logic [7:0]   ack_code_q;
    logic [7:0]   cmd_q;
    logic [7:0]   low_q;
    logic [7:0]   high_q;
    result_t      expected_words[$];

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic result_t ack_word(input logic [7:0] tx, input logic is_last);
        result_t w;
        w.kind    = KIND_ACK;
        w.command = 8'd0;
        w.value   = 16'd0;
        w.tx_byte = tx;
        w.last    = is_last;
        return w;
    endfunction

    task automatic parse_rx_byte(input logic [7:0] b);
        result_t    w;
        logic [7:0] sum;
        case (parse_phase)
            PH_SYNC:
            begin
                if (b == HDR_SECOND)
                    parse_phase = PH_CMD;
                else if (b == HDR_FIRST)
                    parse_phase = PH_SYNC;
                else
                    parse_phase = PH_HUNT;
            end
            PH_CMD:
            begin
                cmd_q       = b;
                parse_phase = PH_LOW;
            end
            PH_LOW:
            begin
                low_q       = b;
                parse_phase = PH_HIGH;
            end
            PH_HIGH:
            begin
                high_q      = b;
                parse_phase = PH_SUM;
            end
            PH_SUM:
            begin
                parse_phase = PH_HUNT;
                sum         = cmd_q + low_q + high_q;
                if (b == ~sum)
                begin
                    w.kind    = KIND_COMMAND;
                    w.command = cmd_q;
                    w.value   = {high_q, low_q};
                    w.tx_byte = 8'd0;
                    w.last    = 1'b0;
                    expected_words.push_back(w);
                    expected_words.push_back(ack_word(HDR_FIRST, 1'b0));
                    expected_words.push_back(ack_word(HDR_SECOND, 1'b0));
                    expected_words.push_back(ack_word(ack_code_q, 1'b0));
                    expected_words.push_back(ack_word(8'd0, 1'b0));
                    expected_words.push_back(ack_word(8'd0, 1'b0));
                    expected_words.push_back(ack_word(~ack_code_q, 1'b1));
                end
            end
            default:
            begin
                if (b == HDR_FIRST)
                    parse_phase = PH_SYNC;
                else
                    parse_phase = PH_HUNT;
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("%0t ns: mismatch: %s", $time, what);
        fail_count++;
    endtask

    task automatic check_word(input result_t got);
        result_t want;
        if (expected_words.size() == 0)
        begin
            report_mismatch($sformatf(
                "unexpected word kind=%0d command=%02h value=%04h tx_byte=%02h last=%0d",
                got.kind, got.command, got.value, got.tx_byte, got.last));
            return;
        end
        want = expected_words.pop_front();
        if (got.kind != want.kind || got.command != want.command || got.value != want.value
            || got.tx_byte != want.tx_byte || got.last != want.last)
            report_mismatch($sformatf(
                "got %0d/%02h/%04h/%02h/%0d, expected %0d/%02h/%04h/%02h/%0d",
                got.kind, got.command, got.value, got.tx_byte, got.last,
                want.kind, want.command, want.value, want.tx_byte, want.last));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            parse_phase = PH_HUNT;
            ack_code_q  = 8'd0;
            cmd_q       = 8'd0;
            low_q       = 8'd0;
            high_q      = 8'd0;
            expected_words.delete();
            pending     = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                ack_code_q = cfg_data;
            if (in_valid && in_ready)
                parse_rx_byte(rx_byte);
            if (out_valid && out_ready)
                check_word(result_t'({kind, command, value, tx_byte, last}));
            pending = expected_words.size();
        end
    end

endmodule

// File: tb/fixed_frame_deframer_with_ack_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// fixed_frame_deframer_with_ack_top_tb
// Drives received bytes and ack code writes into the deframer and gives the
// verdict. Directed frames cover the header and checksum corner cases, then
// mostly well-formed random frames mixed with noise run under random gaps on
// both sides, a gap-free stretch and a long output stall.
// ============================================================================
module fixed_frame_deframer_with_ack_top_tb;
    import ffd_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 200;
    localparam int IDLE_PCT       = 34;
    localparam int TIMEOUT_CYCLES = 200000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [7:0]  cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        out_valid;
    logic        out_ready;
    logic        kind;
    logic [7:0]  command;
    logic [15:0] value;
    logic [7:0]  tx_byte;
    logic        last;

    int fail_count;
    int pending;
    int bytes_sent;
    bit gaps_on;
    bit hold_req;

    fixed_frame_deframer_with_ack_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .rx_byte   (rx_byte),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .kind      (kind),
        .command   (command),
        .value     (value),
        .tx_byte   (tx_byte),
        .last      (last)
    );

    ffd_result_checker result_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .kind       (kind),
        .command    (command),
        .value      (value),
        .tx_byte    (tx_byte),
        .last       (last),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_CYCLES * 20);
        $display("Simulation FAILED");
        $finish;
    end

    // The output side stalls at random and holds off completely on request.
    initial
    begin
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            out_ready <= !gaps_on || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (gaps_on && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] lo,
                              input logic [7:0] hi, input bit corrupt);
        logic [7:0] chk;
        chk = ~(cmd + lo + hi);
        if (corrupt)
            chk = chk ^ 8'($urandom_range(1, 255));
        send_byte(HDR_FIRST);
        send_byte(HDR_SECOND);
        send_byte(cmd);
        send_byte(lo);
        send_byte(hi);
        send_byte(chk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_ack(input logic [7:0] code);
        cfg_valid <= 1'b1;
        cfg_data  <= code;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_traffic(input int n_bytes);
        int         stop_at;
        int         pick;
        logic [7:0] b;
        stop_at = bytes_sent + n_bytes;
        while (bytes_sent < stop_at)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 60)
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'b0);
            else if (pick < 75)
                send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                           8'($urandom_range(0, 255)), 1'b1);
            else if (pick < 85)
            begin
                send_byte(HDR_FIRST);
                b = 8'($urandom_range(0, 255));
                if (b == HDR_SECOND || $urandom_range(0, 1) == 0)
                    b = HDR_FIRST;
                send_byte(b);
            end
            else
                send_byte(8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        rst_n     <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_data  <= 8'd0;
        in_valid  <= 1'b0;
        rx_byte   <= 8'd0;
        gaps_on    = 1'b1;
        hold_req   = 1'b0;
        bytes_sent = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The ack code is still at its reset value for the directed frames.
        send_frame(8'h00, 8'h00, 8'h00, 1'b0);
        send_byte(HDR_FIRST);
        send_frame(8'hff, 8'hff, 8'hff, 1'b0);
        send_byte(HDR_FIRST);
        send_byte(8'h05);
        send_frame(8'ha5, 8'h5a, 8'h3c, 1'b1);
        send_byte(HDR_SECOND);
        drain();

        write_ack(8'hff);
        random_traffic(40);
        drain();

        write_ack(8'($urandom_range(0, 255)));
        gaps_on = 1'b0;
        random_traffic(40);
        drain();

        // The output holds off while full frames keep arriving.
        write_ack(8'h00);
        hold_req = 1'b1;
        repeat (4)
            send_frame(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 1'b0);
        drain();

        gaps_on = 1'b1;
        write_ack(8'($urandom_range(0, 255)));
        random_traffic(30);
        drain();
        repeat (20) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// File: sim.f
rtl/ffd_pkg.sv
rtl/ffd_parser.sv
rtl/ffd_queue.sv
rtl/ffd_emitter.sv
rtl/fixed_frame_deframer_with_ack_top.sv
tb/ffd_result_checker.sv
tb/fixed_frame_deframer_with_ack_top_tb.sv
